FILE: hw/rtl/pida_pkg.sv
// Shared types, codes and helpers for the three-axis PID drive block.
// No dependencies; used by the top level, controller and datapath.
package pida_pkg;

  localparam int DataW  = 16;
  localparam int AccW   = 48;
  localparam int InTdW  = 40;
  localparam int OutTdW = 40;
  localparam logic [15:0] MsPerSec = 16'd1000;
  // ceil(2^36 / 1000): exact quotient by 1000 for any dividend below 2^26
  localparam logic [26:0] MsRecip  = 27'd68719477;
  localparam int          MsShift  = 36;

  typedef enum logic [2:0] {
    CFG_KP   = 3'd0,
    CFG_KI   = 3'd1,
    CFG_KD   = 3'd2,
    CFG_KR   = 3'd3,
    CFG_PER  = 3'd4,
    CFG_DMAX = 3'd5,
    CFG_DMIN = 3'd6,
    CFG_AW   = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_GAP, ST_KI, ST_KRL, ST_KRH, ST_KRSUM, ST_SPL, ST_SPH,
    ST_SPSUM, ST_DIV1, ST_INT, ST_KD, ST_DIV2, ST_SUM, ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_GAP, OP_KI, OP_KRL, OP_KRH, OP_KRSUM, OP_SPL,
    OP_SPH, OP_SPSUM, OP_INT, OP_KD, OP_SUM, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic axis_ok;
    logic div_busy;
    logic out_free;
  } dp_status_t;

  function automatic logic signed [47:0] sat48(input logic signed [65:0] x);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sh0_7FFF_FFFF_FFFF;
    lo = -66'sh0_8000_0000_0000;
    if (x > hi) return 48'sh7FFF_FFFF_FFFF;
    if (x < lo) return -48'sh8000_0000_0000;
    return x[47:0];
  endfunction

endpackage

FILE: hw/rtl/pid_antiwindup_motor_drive_top.sv
// Three-axis speed PID with back-calculation anti-windup, top level.
// From the accepting edge to m_tvalid an item passes a 64-step restoring
// division of the derivative by the period, a four-digit division by 1000
// for the integral and 12 further sequencer steps.
// One item at a time: no new item is taken until the last one has left the
// sequencer; the output register lets the next item in while a result waits.
// Reset (rst, synchronous): registers to defaults, all axis state to zero.
module pid_antiwindup_motor_drive_top #(
  parameter int AXES = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // axis[1:0], reference_speed[17:2], measured_speed[33:18]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // axis_out[1:0], drive[17:2], pwm_level[33:18],
                                 // bridge_a[34], bridge_b[35], stopped[36]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  pida_pkg::dp_cmd_t    cmd;
  pida_pkg::dp_status_t status;

  pida_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  pida_datapath #(.AXES(AXES)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

FILE: hw/rtl/pida_div.sv
// Radix-2 restoring divider, signed dividend by unsigned divisor, floor result.
// Uses pida_pkg nothing but is compiled after it.
module pida_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] dividend,
  input  logic [15:0]        divisor,
  output logic               busy,
  output logic signed [63:0] quotient
);
  localparam int Steps = 64;
  localparam int CntW  = $clog2(Steps + 1);

  logic [CntW-1:0] cnt;
  logic [63:0]     mag;
  logic [16:0]     rem;
  logic [15:0]     dvs;
  logic            neg;
  logic [16:0]     trial;

  assign trial = {rem[15:0], mag[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CntW'(Steps);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CntW'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[63];
      mag <= dividend[63] ? 64'(-dividend) : dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem <= trial - {1'b0, dvs};
        mag <= {mag[62:0], 1'b1};
      end else begin
        rem <= trial;
        mag <= {mag[62:0], 1'b0};
      end
    end
  end

  // floor for negative dividends: -q-1 when a remainder is left
  always_comb begin
    if (!neg) quotient = mag;
    else if (rem != '0) quotient = ~mag;
    else quotient = -mag;
  end

endmodule

FILE: hw/rtl/pida_ctrl.sv
// Sequencer for the PID datapath: one state per arithmetic step.
// Depends on pida_pkg for state, command and status types.
module pida_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pida_pkg::dp_status_t status,
  output pida_pkg::dp_cmd_t    cmd
);
  pida_pkg::state_t state, state_next;
  logic accept;

  assign accept = in_valid && (state == pida_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= pida_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      pida_pkg::ST_IDLE:  if (accept && status.axis_ok) state_next = pida_pkg::ST_GAP;
      pida_pkg::ST_GAP:   state_next = pida_pkg::ST_KI;
      pida_pkg::ST_KI:    state_next = pida_pkg::ST_KRL;
      pida_pkg::ST_KRL:   state_next = pida_pkg::ST_KRH;
      pida_pkg::ST_KRH:   state_next = pida_pkg::ST_KRSUM;
      pida_pkg::ST_KRSUM: state_next = pida_pkg::ST_SPL;
      pida_pkg::ST_SPL:   state_next = pida_pkg::ST_SPH;
      pida_pkg::ST_SPH:   state_next = pida_pkg::ST_SPSUM;
      pida_pkg::ST_SPSUM: state_next = pida_pkg::ST_DIV1;
      pida_pkg::ST_DIV1:  if (!status.div_busy) state_next = pida_pkg::ST_INT;
      pida_pkg::ST_INT:   state_next = pida_pkg::ST_KD;
      pida_pkg::ST_KD:    state_next = pida_pkg::ST_DIV2;
      pida_pkg::ST_DIV2:  if (!status.div_busy) state_next = pida_pkg::ST_SUM;
      pida_pkg::ST_SUM:   state_next = pida_pkg::ST_EMIT;
      pida_pkg::ST_EMIT:  if (status.out_free) state_next = pida_pkg::ST_IDLE;
      default:            state_next = pida_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.op   = pida_pkg::OP_NONE;
    case (state)
      pida_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) cmd.op = pida_pkg::OP_LOAD;
      end
      pida_pkg::ST_GAP:   cmd.op = pida_pkg::OP_GAP;
      pida_pkg::ST_KI:    cmd.op = pida_pkg::OP_KI;
      pida_pkg::ST_KRL:   cmd.op = pida_pkg::OP_KRL;
      pida_pkg::ST_KRH:   cmd.op = pida_pkg::OP_KRH;
      pida_pkg::ST_KRSUM: cmd.op = pida_pkg::OP_KRSUM;
      pida_pkg::ST_SPL:   cmd.op = pida_pkg::OP_SPL;
      pida_pkg::ST_SPH:   cmd.op = pida_pkg::OP_SPH;
      pida_pkg::ST_SPSUM: cmd.op = pida_pkg::OP_SPSUM;
      pida_pkg::ST_INT:   cmd.op = pida_pkg::OP_INT;
      pida_pkg::ST_KD:    cmd.op = pida_pkg::OP_KD;
      pida_pkg::ST_SUM:   cmd.op = pida_pkg::OP_SUM;
      pida_pkg::ST_EMIT:  if (status.out_free) cmd.op = pida_pkg::OP_EMIT;
      default:            cmd.op = pida_pkg::OP_NONE;
    endcase
  end

  a_div_starts: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == pida_pkg::OP_SPSUM || cmd.op == pida_pkg::OP_KD) |=> status.div_busy)
    else $error("divider did not start");
  a_bad_axis_dropped: assert property (@(posedge clk) disable iff (rst)
    (accept && !status.axis_ok) |=> state == pida_pkg::ST_IDLE)
    else $error("out-of-range axis started a step");
  a_emit_holds: assert property (@(posedge clk) disable iff (rst)
    (state == pida_pkg::ST_EMIT && !status.out_free) |=> state == pida_pkg::ST_EMIT)
    else $error("result dropped while output busy");

endmodule

FILE: hw/rtl/pida_datapath.sv
// PID datapath: config registers, per-axis state, shared multiplier, divider
// and output register. Depends on pida_pkg and pida_div.
module pida_datapath #(
  parameter int AXES = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pida_pkg::dp_cmd_t    cmd,
  output pida_pkg::dp_status_t status,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic [pida_pkg::InTdW-1:0]  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [pida_pkg::OutTdW-1:0] out_data
);
  localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;

  logic signed [15:0] kp, ki, kd, kr, dmax, dmin;
  logic [15:0]        per;
  logic               aw;

  logic signed [47:0] ia_mem [AXES];
  logic signed [16:0] pe_mem [AXES];
  logic signed [47:0] pu_mem [AXES];
  logic signed [15:0] pc_mem [AXES];

  logic [1:0]         in_axis;
  logic signed [15:0] in_ref, in_meas;
  logic [AW-1:0]      ax;
  logic [1:0]         ax_raw;
  logic               stop;
  logic signed [16:0] e;
  logic signed [17:0] de;
  logic signed [47:0] gap, p, sk, s, ia, u;
  logic signed [41:0] t, prod;
  logic signed [24:0] mul_a;
  logic signed [16:0] mul_b;
  logic [15:0]        per_eff;

  logic               div_start, div_busy;
  logic signed [63:0] div_dividend, div_q;
  logic [15:0]        div_divisor;

  assign in_axis = in_data[1:0];
  assign in_ref  = in_data[17:2];
  assign in_meas = in_data[33:18];
  assign per_eff = (per == 16'd0) ? 16'd1 : per;

  assign status.axis_ok  = ({30'd0, in_axis} < AXES);
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp <= 16'sd256; ki <= 16'sd128; kd <= 16'sd0; kr <= 16'sd256;
      per <= 16'd351; dmax <= 16'sd8000; dmin <= -16'sd8000; aw <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        pida_pkg::CFG_KP:   kp   <= cfg_data;
        pida_pkg::CFG_KI:   ki   <= cfg_data;
        pida_pkg::CFG_KD:   kd   <= cfg_data;
        pida_pkg::CFG_KR:   kr   <= cfg_data;
        pida_pkg::CFG_PER:  per  <= cfg_data;
        pida_pkg::CFG_DMAX: dmax <= cfg_data;
        pida_pkg::CFG_DMIN: dmin <= cfg_data;
        pida_pkg::CFG_AW:   aw   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // shared multiplier, product registered every cycle
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      pida_pkg::OP_GAP: begin mul_a = 25'(e); mul_b = 17'(kp); end
      pida_pkg::OP_KI:  begin mul_a = 25'(e); mul_b = 17'(ki); end
      pida_pkg::OP_KRL: begin mul_a = {1'b0, gap[23:0]}; mul_b = 17'(kr); end
      pida_pkg::OP_KRH: begin mul_a = 25'($signed(gap[47:24])); mul_b = 17'(kr); end
      pida_pkg::OP_SPL: begin mul_a = {1'b0, s[23:0]}; mul_b = {1'b0, per_eff}; end
      pida_pkg::OP_SPH: begin mul_a = 25'($signed(s[47:24])); mul_b = {1'b0, per_eff}; end
      pida_pkg::OP_INT: begin mul_a = 25'(de); mul_b = 17'(kd); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) prod <= mul_a * mul_b;

  // gap between last clamped and last unclamped whole parts
  logic signed [47:0] pu_r;
  logic signed [48:0] pu_mag, pu_whole;
  logic signed [49:0] whole;
  logic signed [65:0] gap_full;
  assign pu_r     = pu_mem[ax];
  assign pu_mag   = pu_r[47] ? -49'(pu_r) : 49'(pu_r);
  assign pu_whole = {pu_mag[48:16], 16'h0000};
  assign whole    = pu_r[47] ? -50'(pu_whole) : 50'(pu_whole);
  assign gap_full = (66'(pc_mem[ax]) <<< 16) - 66'(whole);

  logic signed [63:0] wide, kdx, kdx1000;
  assign wide    = (64'(prod) <<< 24) + 64'(t);
  assign kdx     = 64'(prod);
  assign kdx1000 = (kdx <<< 10) - (kdx <<< 4) - (kdx <<< 3);

  // integral scaling by 1000: four 16-bit digits, top first, each digit by
  // reciprocal multiplication with the remainder carried down
  logic               kq_start, kq_busy, kq_neg;
  logic [2:0]         kq_cnt;
  logic [63:0]        kq_mag;
  logic [9:0]         kq_rem;
  logic [25:0]        kq_num, kq_back;
  logic [52:0]        kq_prod;
  logic [15:0]        kq_digit;
  logic signed [63:0] kq_quot;

  assign kq_start = (cmd.op == pida_pkg::OP_SPSUM);
  assign kq_num   = {kq_rem, kq_mag[63:48]};
  assign kq_prod  = 53'(kq_num) * 53'(pida_pkg::MsRecip);
  assign kq_digit = kq_prod[pida_pkg::MsShift+15:pida_pkg::MsShift];
  assign kq_back  = 26'(kq_digit) * 26'(pida_pkg::MsPerSec);

  always_ff @(posedge clk) begin
    if (rst) begin
      kq_busy <= 1'b0;
      kq_cnt  <= '0;
    end else if (kq_start) begin
      kq_busy <= 1'b1;
      kq_cnt  <= 3'd4;
    end else if (kq_busy) begin
      kq_cnt <= kq_cnt - 3'd1;
      if (kq_cnt == 3'd1) kq_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (kq_start) begin
      kq_neg <= wide[63];
      kq_mag <= wide[63] ? 64'(-wide) : wide;
      kq_rem <= '0;
    end else if (kq_busy) begin
      kq_mag <= {kq_mag[47:0], kq_digit};
      kq_rem <= 10'(kq_num - kq_back);
    end
  end

  // floor for negative dividends: -q-1 when a remainder is left
  always_comb begin
    if (!kq_neg) kq_quot = kq_mag;
    else if (kq_rem != '0) kq_quot = ~kq_mag;
    else kq_quot = -kq_mag;
  end

  assign status.div_busy = div_busy || kq_busy;

  assign div_start    = (cmd.op == pida_pkg::OP_KD);
  assign div_dividend = kdx1000 <<< 8;
  assign div_divisor  = per_eff;

  pida_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // clamp and truncate toward zero
  logic signed [47:0] hi_lim, lo_lim, clamped;
  logic signed [48:0] c_mag;
  logic signed [15:0] drive, d_mag;
  assign hi_lim  = 48'(dmax) <<< 16;
  assign lo_lim  = 48'(dmin) <<< 16;
  assign clamped = (u >= hi_lim) ? hi_lim : ((u <= lo_lim) ? lo_lim : u);
  assign c_mag   = clamped[47] ? -49'(clamped) : 49'(clamped);
  assign d_mag   = c_mag[31:16];
  assign drive   = clamped[47] ? -d_mag : d_mag;

  always_ff @(posedge clk) begin
    case (cmd.op)
      pida_pkg::OP_LOAD: begin
        ax     <= AW'(in_axis);
        ax_raw <= in_axis;
        stop   <= (in_ref == 16'sd0);
        e      <= 17'(in_ref) - 17'(in_meas);
      end
      pida_pkg::OP_GAP: begin
        gap <= pida_pkg::sat48(gap_full);
        de  <= 18'(e) - 18'(pe_mem[ax]);
      end
      pida_pkg::OP_KI:    p  <= {prod[39:0], 8'h00};
      pida_pkg::OP_KRL:   sk <= {prod[39:0], 8'h00};
      pida_pkg::OP_KRH:   t  <= prod;
      pida_pkg::OP_KRSUM: s  <= pida_pkg::sat48(66'(sk) + (aw ? 66'(wide >>> 8) : 66'sd0));
      pida_pkg::OP_SPH:   t  <= prod;
      pida_pkg::OP_INT:   ia <= pida_pkg::sat48(66'(ia_mem[ax]) + 66'(kq_quot));
      pida_pkg::OP_SUM:   u  <= pida_pkg::sat48(66'(p) + 66'(ia) + 66'(div_q));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        ia_mem[i] <= '0; pe_mem[i] <= '0; pu_mem[i] <= '0; pc_mem[i] <= '0;
      end
    end else if (cmd.op == pida_pkg::OP_EMIT) begin
      ia_mem[ax] <= ia;
      pe_mem[ax] <= e;
      pu_mem[ax] <= u;
      pc_mem[ax] <= drive;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.op == pida_pkg::OP_EMIT) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.op == pida_pkg::OP_EMIT) begin
      out_data[1:0]   <= ax_raw;
      out_data[17:2]  <= drive;
      out_data[33:18] <= stop ? 16'd0 : d_mag;
      out_data[34]    <= !stop && !clamped[47];
      out_data[35]    <= !stop && clamped[47];
      out_data[36]    <= stop;
      out_data[39:37] <= 3'b000;
    end
  end

endmodule
